[sv/thsm_pkg.sv]
// Shared types and constants of the two-wire humidity sensor master.
package thsm_pkg;

    localparam int unsigned PHASE_W = 5;

    localparam logic [PHASE_W-1:0] PH_IDLE     = 5'd0;
    localparam logic [PHASE_W-1:0] PH_ST1      = 5'd1;
    localparam logic [PHASE_W-1:0] PH_ST2      = 5'd2;
    localparam logic [PHASE_W-1:0] PH_ST3      = 5'd3;
    localparam logic [PHASE_W-1:0] PH_ST4      = 5'd4;
    localparam logic [PHASE_W-1:0] PH_ST5      = 5'd5;
    localparam logic [PHASE_W-1:0] PH_ST6      = 5'd6;
    localparam logic [PHASE_W-1:0] PH_CMD_DATA = 5'd7;
    localparam logic [PHASE_W-1:0] PH_CMD_CLKH = 5'd8;
    localparam logic [PHASE_W-1:0] PH_CMD_CLKL = 5'd9;
    localparam logic [PHASE_W-1:0] PH_ACK_REL  = 5'd10;
    localparam logic [PHASE_W-1:0] PH_ACK_LOW  = 5'd11;
    localparam logic [PHASE_W-1:0] PH_ACK_HIGH = 5'd12;
    localparam logic [PHASE_W-1:0] PH_WAIT     = 5'd13;
    localparam logic [PHASE_W-1:0] PH_RD1_H    = 5'd14;
    localparam logic [PHASE_W-1:0] PH_RD1_S    = 5'd15;
    localparam logic [PHASE_W-1:0] PH_MACK_DH  = 5'd16;
    localparam logic [PHASE_W-1:0] PH_MACK_DL  = 5'd17;
    localparam logic [PHASE_W-1:0] PH_MACK_CH  = 5'd18;
    localparam logic [PHASE_W-1:0] PH_MACK_CL  = 5'd19;
    localparam logic [PHASE_W-1:0] PH_RD2_REL  = 5'd20;
    localparam logic [PHASE_W-1:0] PH_RD2_H    = 5'd21;
    localparam logic [PHASE_W-1:0] PH_RD2_S    = 5'd22;
    localparam logic [PHASE_W-1:0] PH_END_D    = 5'd23;
    localparam logic [PHASE_W-1:0] PH_END_CH   = 5'd24;
    localparam logic [PHASE_W-1:0] PH_END_CL   = 5'd25;

    localparam int unsigned LVL_CLK = 0;
    localparam int unsigned LVL_DAT = 1;
    localparam int unsigned LVL_DRV = 2;

    localparam logic [2:0] ERR_ACK_LOW  = 3'b001;
    localparam logic [2:0] ERR_ACK_HIGH = 3'b010;
    localparam logic [2:0] ERR_TIMEOUT  = 3'b100;

    localparam logic [15:0] WAIT_LIMIT_RESET = 16'd100;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [3:0]         bit_count;
        logic [15:0]        shift_word;
        logic [7:0]         command_hold;
        logic [15:0]        poll_count;
        logic [2:0]         error_hold;
        logic [2:0]         line_levels;
    } t_state;

    typedef struct packed {
        logic        clock_out;
        logic        data_out;
        logic        data_drive;
        logic        busy_res;
        logic        done_res;
        logic [15:0] reading;
        logic [2:0]  error_flags;
    } t_result;

endpackage

[sv/thsm_step.sv]
// Next-state and result logic for one bit-time tick of the sensor exchange.
module thsm_step (
    input  thsm_pkg::t_state  i_state,
    input  logic              i_mode,
    input  logic [7:0]        i_command,
    input  logic              i_data_in,
    input  logic [15:0]       i_wait_limit,
    output thsm_pkg::t_state  o_state,
    output thsm_pkg::t_result o_result
);

    logic        done;
    logic [3:0]  bit_inc;
    logic [15:0] poll_inc;
    logic [2:0]  cmd_idx;

    assign bit_inc  = i_state.bit_count + 4'd1;
    assign poll_inc = i_state.poll_count + 16'd1;
    assign cmd_idx  = 3'd7 - i_state.bit_count[2:0];

    always_comb begin
        o_state = i_state;
        done    = 1'b0;
        unique case (i_state.phase) inside
            thsm_pkg::PH_IDLE: begin
                if (i_mode) begin
                    o_state.command_hold = i_command;
                    o_state.error_hold   = 3'd0;
                    o_state.shift_word   = 16'd0;
                    o_state.bit_count    = 4'd0;
                    o_state.poll_count   = 16'd0;
                    o_state.line_levels  = 3'd0;
                    o_state.line_levels[thsm_pkg::LVL_DRV] = 1'b1;
                    o_state.line_levels[thsm_pkg::LVL_DAT] = 1'b1;
                    o_state.phase = thsm_pkg::PH_ST1;
                end
            end
            thsm_pkg::PH_ST1: begin
                o_state.line_levels[thsm_pkg::LVL_CLK] = 1'b1;
                o_state.phase = thsm_pkg::PH_ST2;
            end
            thsm_pkg::PH_ST2: begin
                o_state.line_levels[thsm_pkg::LVL_DAT] = 1'b0;
                o_state.phase = thsm_pkg::PH_ST3;
            end
            thsm_pkg::PH_ST3: begin
                o_state.line_levels[thsm_pkg::LVL_CLK] = 1'b0;
                o_state.phase = thsm_pkg::PH_ST4;
            end
            thsm_pkg::PH_ST4: begin
                o_state.line_levels[thsm_pkg::LVL_CLK] = 1'b1;
                o_state.phase = thsm_pkg::PH_ST5;
            end
            thsm_pkg::PH_ST5: begin
                o_state.line_levels[thsm_pkg::LVL_DAT] = 1'b1;
                o_state.phase = thsm_pkg::PH_ST6;
            end
            thsm_pkg::PH_ST6: begin
                o_state.line_levels[thsm_pkg::LVL_CLK] = 1'b0;
                o_state.bit_count = 4'd0;
                o_state.phase = thsm_pkg::PH_CMD_DATA;
            end
            thsm_pkg::PH_CMD_DATA: begin
                o_state.line_levels[thsm_pkg::LVL_DRV] = 1'b1;
                o_state.line_levels[thsm_pkg::LVL_DAT] = i_state.command_hold[cmd_idx];
                o_state.phase = thsm_pkg::PH_CMD_CLKH;
            end
            thsm_pkg::PH_CMD_CLKH: begin
                o_state.line_levels[thsm_pkg::LVL_CLK] = 1'b1;
                o_state.phase = thsm_pkg::PH_CMD_CLKL;
            end
            thsm_pkg::PH_CMD_CLKL: begin
                o_state.line_levels[thsm_pkg::LVL_CLK] = 1'b0;
                if (i_state.bit_count >= 4'd7) begin
                    o_state.bit_count = 4'd0;
                    o_state.phase = thsm_pkg::PH_ACK_REL;
                end else begin
                    o_state.bit_count = bit_inc;
                    o_state.phase = thsm_pkg::PH_CMD_DATA;
                end
            end
            thsm_pkg::PH_ACK_REL: begin
                o_state.line_levels[thsm_pkg::LVL_CLK] = 1'b1;
                o_state.line_levels[thsm_pkg::LVL_DRV] = 1'b0;
                o_state.line_levels[thsm_pkg::LVL_DAT] = 1'b0;
                o_state.phase = thsm_pkg::PH_ACK_LOW;
            end
            thsm_pkg::PH_ACK_LOW: begin
                if (i_data_in) begin
                    o_state.error_hold = i_state.error_hold | thsm_pkg::ERR_ACK_LOW;
                end
                o_state.line_levels[thsm_pkg::LVL_CLK] = 1'b0;
                o_state.phase = thsm_pkg::PH_ACK_HIGH;
            end
            thsm_pkg::PH_ACK_HIGH: begin
                if (!i_data_in) begin
                    o_state.error_hold = i_state.error_hold | thsm_pkg::ERR_ACK_HIGH;
                end
                o_state.poll_count = 16'd0;
                o_state.phase = thsm_pkg::PH_WAIT;
            end
            thsm_pkg::PH_WAIT: begin
                o_state.poll_count = poll_inc;
                if (!i_data_in) begin
                    o_state.bit_count  = 4'd0;
                    o_state.shift_word = 16'd0;
                    o_state.phase = thsm_pkg::PH_RD1_H;
                end else if (poll_inc >= i_wait_limit || poll_inc == 16'd0) begin
                    o_state.error_hold = i_state.error_hold | thsm_pkg::ERR_TIMEOUT;
                    o_state.bit_count  = 4'd0;
                    o_state.shift_word = 16'd0;
                    o_state.phase = thsm_pkg::PH_RD1_H;
                end
            end
            thsm_pkg::PH_RD1_H, thsm_pkg::PH_RD2_H: begin
                o_state.line_levels[thsm_pkg::LVL_CLK] = 1'b1;
                o_state.phase = (i_state.phase == thsm_pkg::PH_RD1_H) ?
                                thsm_pkg::PH_RD1_S : thsm_pkg::PH_RD2_S;
            end
            thsm_pkg::PH_RD1_S, thsm_pkg::PH_RD2_S: begin
                o_state.shift_word = {i_state.shift_word[14:0], i_data_in};
                o_state.line_levels[thsm_pkg::LVL_CLK] = 1'b0;
                if (bit_inc >= 4'd8) begin
                    o_state.bit_count = 4'd0;
                    o_state.phase = (i_state.phase == thsm_pkg::PH_RD1_S) ?
                                    thsm_pkg::PH_MACK_DH : thsm_pkg::PH_END_D;
                end else begin
                    o_state.bit_count = bit_inc;
                    o_state.phase = (i_state.phase == thsm_pkg::PH_RD1_S) ?
                                    thsm_pkg::PH_RD1_H : thsm_pkg::PH_RD2_H;
                end
            end
            thsm_pkg::PH_MACK_DH, thsm_pkg::PH_END_D: begin
                o_state.line_levels[thsm_pkg::LVL_DRV] = 1'b1;
                o_state.line_levels[thsm_pkg::LVL_DAT] = 1'b1;
                o_state.phase = (i_state.phase == thsm_pkg::PH_MACK_DH) ?
                                thsm_pkg::PH_MACK_DL : thsm_pkg::PH_END_CH;
            end
            thsm_pkg::PH_MACK_DL: begin
                o_state.line_levels[thsm_pkg::LVL_DAT] = 1'b0;
                o_state.phase = thsm_pkg::PH_MACK_CH;
            end
            thsm_pkg::PH_MACK_CH, thsm_pkg::PH_END_CH: begin
                o_state.line_levels[thsm_pkg::LVL_CLK] = 1'b1;
                o_state.phase = (i_state.phase == thsm_pkg::PH_MACK_CH) ?
                                thsm_pkg::PH_MACK_CL : thsm_pkg::PH_END_CL;
            end
            thsm_pkg::PH_MACK_CL: begin
                o_state.line_levels[thsm_pkg::LVL_CLK] = 1'b0;
                o_state.phase = thsm_pkg::PH_RD2_REL;
            end
            thsm_pkg::PH_RD2_REL: begin
                o_state.line_levels[thsm_pkg::LVL_DRV] = 1'b0;
                o_state.line_levels[thsm_pkg::LVL_DAT] = 1'b0;
                o_state.bit_count = 4'd0;
                o_state.phase = thsm_pkg::PH_RD2_H;
            end
            thsm_pkg::PH_END_CL: begin
                o_state.line_levels[thsm_pkg::LVL_CLK] = 1'b0;
                done = 1'b1;
                o_state.phase = thsm_pkg::PH_IDLE;
            end
            default: begin
                o_state.phase = thsm_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb begin
        o_result.clock_out   = o_state.line_levels[thsm_pkg::LVL_CLK];
        o_result.data_out    = o_state.line_levels[thsm_pkg::LVL_DAT];
        o_result.data_drive  = o_state.line_levels[thsm_pkg::LVL_DRV];
        o_result.busy_res    = (o_state.phase != thsm_pkg::PH_IDLE);
        o_result.done_res    = done;
        o_result.reading     = done ? o_state.shift_word : 16'd0;
        o_result.error_flags = o_state.error_hold;
    end

endmodule

[sv/two_wire_humidity_sensor_master.sv]
// Top level of the two-wire humidity sensor master with its handshake registers.
// Usage: every input transaction is either a bit-time tick (i_mode = 0) carrying
// the sampled data line level in i_data_in, or a start request (i_mode = 1)
// carrying the command byte in i_command. Each input transaction yields exactly
// one output transaction with the clock, data and drive levels to put on the
// lines, the busy and done flags, the 16-bit reading (nonzero only with done)
// and the sticky error flags.
// The input is registered, and one tick of the sequencer then updates the
// exchange state and the output register once the output register is free to
// take the result. One transaction is accepted per cycle while the receiver
// takes each output; the sequencer step itself is combinational.
// When the receiver holds i_out_ready low, the output register holds its
// transaction, the input register fills, and o_in_ready falls until the output
// is taken. The configuration channel writes the wait limit and is always
// ready; write it only while no transaction is in flight.
// Synchronous reset returns the sequencer to idle with the clock low and the
// data line released, clears the error flags, empties both registers and sets
// the wait limit to 100.
module two_wire_humidity_sensor_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_command,
    input  logic        i_data_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_clock_out,
    output logic        o_data_out,
    output logic        o_data_drive,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [15:0] o_reading,
    output logic [2:0]  o_error_flags,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic               r_in_valid;
    logic               r_mode;
    logic [7:0]         r_command;
    logic               r_data_in;
    logic               r_out_valid;
    logic [15:0]        r_wait_limit;
    thsm_pkg::t_state   r_state;
    thsm_pkg::t_state   n_state;
    thsm_pkg::t_result  r_result;
    thsm_pkg::t_result  n_result;
    logic               advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    thsm_step u_step (
        .i_state      (r_state),
        .i_mode       (r_mode),
        .i_command    (r_command),
        .i_data_in    (r_data_in),
        .i_wait_limit (r_wait_limit),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_wait_limit <= thsm_pkg::WAIT_LIMIT_RESET;
            r_state      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_wait_limit <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mode    <= i_mode;
            r_command <= i_command;
            r_data_in <= i_data_in;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_clock_out   = r_result.clock_out;
    assign o_data_out    = r_result.data_out;
    assign o_data_drive  = r_result.data_drive;
    assign o_busy_res    = r_result.busy_res;
    assign o_done_res    = r_result.done_res;
    assign o_reading     = r_result.reading;
    assign o_error_flags = r_result.error_flags;

endmodule
